// ===== sv/positional_list_table_defines.svh =====
// ----------------------------------------------------------------------------
// positional_list_table assertion macros
// shared clocked assertion forms for the list table
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_TABLE_DEFINES_SVH
`define POSITIONAL_LIST_TABLE_DEFINES_SVH

// checked on every edge outside reset
`define PLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg
// types and constants shared by the list table and its cells
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

  localparam int DEPTH_DEFAULT = 32;
  // counts and cell indexes cover depths up to 127
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_UPDATE = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_LIST   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_AT_END    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_POS   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_UPDATE,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_LIST
  } state_t;

  typedef struct packed {
    logic signed [31:0] id;
    logic [15:0]        first_code;
    logic [15:0]        second_code;
  } rec_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] count;
    rec_t             data;
  } cell_ctrl_t;

  typedef struct packed {
    status_t          status;
    rec_t             rec;
    logic [CNT_W-1:0] pos;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/plt_cell.sv =====
// ----------------------------------------------------------------------------
// plt_cell
// one record slot of the chain; loads from its neighbors, the head or the bus
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plt_cell
  import plt_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       sel,
  input  wire rec_t       left,
  input  wire rec_t       right,
  input  wire rec_t       head,
  output rec_t            rec,
  output logic            match
);

  localparam logic [CNT_W-1:0] ME    = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] ME_P1 = CNT_W'(IDX + 1);

  rec_t rec_next;

  always_comb begin
    rec_next = rec;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (ME == ctrl.idx) begin
          rec_next = ctrl.data;
        end else if (ME > ctrl.idx && ME <= ctrl.count) begin
          rec_next = left;
        end
      end
      OP_DELETE: begin
        if (ME >= ctrl.idx && ME_P1 < ctrl.count) begin
          rec_next = right;
        end
      end
      OP_UPDATE: begin
        if (sel) begin
          rec_next.first_code  = ctrl.data.first_code;
          rec_next.second_code = ctrl.data.second_code;
        end
      end
      OP_ROTATE: begin
        // the last used cell wraps around to the head record
        if (ME_P1 == ctrl.count) begin
          rec_next = head;
        end else if (ME_P1 < ctrl.count) begin
          rec_next = right;
        end
      end
      default: begin
        rec_next = rec;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

  assign match = (ME < ctrl.count) && (rec.id == ctrl.data.id);

endmodule

`default_nettype wire

// ===== sv/positional_list_table.sv =====
// ----------------------------------------------------------------------------
// positional_list_table
// bounded ordered record list kept in a chain of cells
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, one per transfer, with the command
// kind in s_axis_tuser: append, insert at a 1-based position, update names by
// id, delete at a position, or list. Results leave on m_axis; m_axis_tlast
// marks the final result of each command.
// Append, insert, update and delete are done by every cell at the accepting
// edge; their single status result is written into the result queue there.
// A list command rotates the chain by one cell per cycle and emits one record
// per cycle while the result queue has room, starting in the S_LIST state
// entered after it is taken; s_axis_tready stays low in S_LIST, so the next
// command is taken only after the last record is queued (an empty list just
// returns ST_EMPTY). The chain is back in order after the last record.
// A two-entry result queue sits in front of m_axis, so a command is still
// taken while one result waits. When the receiver stalls the queue fills and
// s_axis_tready drops; a list pauses its rotation until room returns.
// Reset (rst, synchronous) empties the list and the result queue; cell
// contents are not cleared, since only cells below the count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_table_defines.svh"

module positional_list_table
  import plt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // record_id[31:0], first_name_code[47:32], second_name_code[63:48],
  // position[71:64]
  input  wire logic [71:0] s_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], entry_id[34:3], entry_first_code[50:35],
  // entry_second_code[66:51], entry_position[73:67], zero[79:74]
  output logic [79:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  state_t           state, state_next;
  logic [CNT_W-1:0] used_count, used_count_next;
  logic [CNT_W-1:0] lcnt, lcnt_next;
  logic [CNT_W-1:0] lcnt_p1;

  cell_ctrl_t       ctrl;
  rec_t             rec_arr   [DEPTH];
  rec_t             left_arr  [DEPTH];
  rec_t             right_arr [DEPTH];
  logic [DEPTH-1:0] match_v;
  logic [DEPTH-1:0] first_hit;

  result_t          res;
  result_t          slot0, slot1;
  logic [1:0]       fcnt;
  logic             push, pop, push_ok;

  logic             in_fire;
  kind_t            kind;
  rec_t             in_rec;
  logic [7:0]       in_pos;
  logic [7:0]       eff_m1;
  logic [7:0]       count8;
  logic             full_try;

  // --------------------------------------------------------------------------
  // cell chain
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_left_head
      assign left_arr[g] = ctrl.data;
    end else begin : g_left_mid
      assign left_arr[g] = rec_arr[g-1];
    end
    if (g == DEPTH - 1) begin : g_right_tail
      assign right_arr[g] = rec_arr[g];
    end else begin : g_right_mid
      assign right_arr[g] = rec_arr[g+1];
    end

    plt_cell #(
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .sel   (first_hit[g]),
      .left  (left_arr[g]),
      .right (right_arr[g]),
      .head  (rec_arr[0]),
      .rec   (rec_arr[g]),
      .match (match_v[g])
    );
  end

  // lowest matching cell wins
  assign first_hit = match_v & (~match_v + DEPTH'(1));

  // --------------------------------------------------------------------------
  // command decode
  // --------------------------------------------------------------------------
  assign push_ok       = (fcnt != 2'd2);
  assign s_axis_tready = (state == S_IDLE) && push_ok;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign kind               = kind_t'(s_axis_tuser);
  assign in_rec.id          = s_axis_tdata[31:0];
  assign in_rec.first_code  = s_axis_tdata[47:32];
  assign in_rec.second_code = s_axis_tdata[63:48];
  assign in_pos             = s_axis_tdata[71:64];

  // position zero on insert behaves as position two
  assign eff_m1  = (in_pos == 8'd0) ? 8'd1 : (in_pos - 8'd1);
  assign count8  = {1'b0, used_count};
  assign lcnt_p1 = lcnt + CNT_W'(1);

  always_comb begin
    ctrl.op         = OP_HOLD;
    ctrl.idx        = '0;
    ctrl.count      = used_count;
    ctrl.data       = in_rec;
    res             = '0;
    res.status      = ST_OK;
    res.last        = 1'b1;
    push            = 1'b0;
    used_count_next = used_count;
    state_next      = state;
    lcnt_next       = lcnt;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          push = 1'b1;
          unique case (kind) inside
            KIND_APPEND, KIND_INSERT: begin
              if (used_count == DEPTH_C) begin
                res.status = ST_FULL;
              end else begin
                ctrl.op         = OP_INSERT;
                used_count_next = used_count + CNT_W'(1);
                if (kind == KIND_APPEND) begin
                  ctrl.idx = used_count;
                end else if (in_pos == 8'd1) begin
                  ctrl.idx = '0;
                end else if (used_count == '0 || eff_m1 > count8) begin
                  ctrl.idx   = used_count;
                  res.status = ST_AT_END;
                end else begin
                  ctrl.idx = eff_m1[CNT_W-1:0];
                end
              end
            end
            KIND_UPDATE: begin
              if (|match_v) begin
                ctrl.op = OP_UPDATE;
              end else begin
                res.status = ST_NOT_FOUND;
              end
            end
            KIND_DELETE: begin
              if (used_count == '0) begin
                res.status = ST_EMPTY;
              end else if (in_pos == 8'd0 || in_pos > count8) begin
                res.status = ST_BAD_POS;
              end else begin
                ctrl.op         = OP_DELETE;
                ctrl.idx        = eff_m1[CNT_W-1:0];
                used_count_next = used_count - CNT_W'(1);
              end
            end
            KIND_LIST: begin
              if (used_count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                push       = 1'b0;
                lcnt_next  = '0;
                state_next = S_LIST;
              end
            end
            default: begin
              res.status = ST_OK;
            end
          endcase
        end
      end
      S_LIST: begin
        if (push_ok) begin
          ctrl.op    = OP_ROTATE;
          push       = 1'b1;
          res.rec    = rec_arr[0];
          res.pos    = lcnt_p1;
          res.last   = (lcnt_p1 == used_count);
          lcnt_next  = lcnt_p1;
          if (lcnt_p1 == used_count) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      lcnt       <= '0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      lcnt       <= lcnt_next;
    end
  end

  // --------------------------------------------------------------------------
  // two-entry result queue
  // --------------------------------------------------------------------------
  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= 2'd0;
    end else begin
      fcnt <= fcnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && fcnt == 2'd1) begin
        slot0 <= res;
      end else begin
        slot0 <= slot1;
      end
    end else if (push) begin
      if (fcnt == 2'd0) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end
  end

  assign m_axis_tvalid = (fcnt != 2'd0);
  assign m_axis_tlast  = slot0.last;
  assign m_axis_tdata  = {6'b0, slot0.pos, slot0.rec.second_code,
                          slot0.rec.first_code, slot0.rec.id, slot0.status};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  assign full_try = in_fire && (kind == KIND_APPEND || kind == KIND_INSERT) &&
                    used_count == DEPTH_C;

  `PLT_ASSERT_ALWAYS(a_fcnt_range, rst || fcnt != 2'd3, "result queue overflow")
  `PLT_ASSERT(a_count_bound, used_count <= DEPTH_C, "record count beyond depth")
  `PLT_ASSERT(a_list_bound, state == S_LIST |-> lcnt < used_count, "list index past count")
  `PLT_ASSERT(a_full_hold, full_try |=> $stable(used_count), "full table grew")
  `PLT_ASSERT(a_list_keeps, state == S_LIST |=> $stable(used_count), "count moved in list")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the positional list table
// ----------------------------------------------------------------------------
// Commands go in on s_axis and replies come back on m_axis. A shadow copy of
// the list predicts every reply. Replies are checked in order, field by field.
// The bench runs a short directed list first, with hand-typed status where it
// is obvious, then fills the list to capacity. After that come about 300
// random commands that churn the list, grow it and drain it. Both sides idle
// at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import plt_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int RANDOM_CMDS = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  // kinds the block takes but ignores
  localparam logic [2:0] KIND_RSVD5 = 3'd5;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;
  localparam logic signed [31:0] ID_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ID_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] id;
    logic [15:0]        first_code;
    logic [15:0]        second_code;
    logic [7:0]         pos;
    bit                 typed;
    status_t            want;
  } cmd_row_t;

  typedef struct {
    status_t            status;
    logic signed [31:0] id;
    logic [15:0]        first_code;
    logic [15:0]        second_code;
    logic [6:0]         pos;
    logic               last;
  } list_reply_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // record_id[31:0], first_name_code[47:32], second_name_code[63:48],
  // position[71:64]
  logic [71:0] s_axis_tdata;
  // kind[2:0]
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // status[2:0], entry_id[34:3], entry_first_code[50:35],
  // entry_second_code[66:51], entry_position[73:67], zero[79:74]
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;

  positional_list_table #(.DEPTH(DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // shadow copy of the list
  logic signed [31:0] shadow_ids [DEPTH];
  logic [15:0]        shadow_first [DEPTH];
  logic [15:0]        shadow_second [DEPTH];
  int                 shadow_count;

  list_reply_t pending_replies [$];
  int          mismatch_count;
  int          cycle_count;
  bit          calm;
  bit          hold_request;

  cmd_row_t opening_rows [23] = '{
    '{KIND_LIST,   0,          16'h0000, 16'h0000, 8'd0,   1, ST_EMPTY},
    '{KIND_DELETE, 0,          16'h0000, 16'h0000, 8'd1,   1, ST_EMPTY},
    '{KIND_UPDATE, 7,          16'h0001, 16'h0001, 8'd0,   1, ST_NOT_FOUND},
    '{KIND_INSERT, ID_MAX,     16'hffff, 16'hffff, 8'd0,   1, ST_AT_END},
    '{KIND_APPEND, ID_MIN,     16'h0000, 16'hffff, 8'd0,   1, ST_OK},
    '{KIND_INSERT, 0,          16'hffff, 16'h0000, 8'd1,   1, ST_OK},
    '{KIND_INSERT, -1,         16'h5555, 16'haaaa, 8'd0,   1, ST_OK},
    '{KIND_INSERT, 32'h1234_5678, 16'haaaa, 16'h5555, 8'd5, 1, ST_OK},
    '{KIND_INSERT, ID_MAX,     16'h0001, 16'h8000, 8'd255, 1, ST_AT_END},
    '{KIND_INSERT, 3,          16'h1234, 16'h4321, 8'd3,   0, ST_OK},
    '{KIND_LIST,   0,          16'h0000, 16'h0000, 8'd0,   0, ST_OK},
    '{KIND_UPDATE, ID_MAX,     16'hbeef, 16'hcafe, 8'd0,   1, ST_OK},
    '{KIND_UPDATE, ID_MIN,     16'h8001, 16'h7ffe, 8'd0,   1, ST_OK},
    '{KIND_UPDATE, 99,         16'h0000, 16'h0000, 8'd0,   1, ST_NOT_FOUND},
    '{KIND_DELETE, 0,          16'h0000, 16'h0000, 8'd0,   1, ST_BAD_POS},
    '{KIND_DELETE, 0,          16'h0000, 16'h0000, 8'd8,   1, ST_BAD_POS},
    '{KIND_DELETE, 0,          16'h0000, 16'h0000, 8'd255, 1, ST_BAD_POS},
    '{KIND_DELETE, 0,          16'h0000, 16'h0000, 8'd1,   1, ST_OK},
    '{KIND_DELETE, 0,          16'h0000, 16'h0000, 8'd6,   1, ST_OK},
    '{KIND_DELETE, 0,          16'h0000, 16'h0000, 8'd3,   1, ST_OK},
    '{KIND_RSVD5,  ID_MAX,     16'hffff, 16'hffff, 8'd255, 1, ST_OK},
    '{KIND_RSVD7,  -1,         16'hffff, 16'hffff, 8'd1,   1, ST_OK},
    '{KIND_LIST,   0,          16'h0000, 16'h0000, 8'd0,   0, ST_OK}
  };

  // run once the list has been filled to capacity
  cmd_row_t full_rows [5] = '{
    '{KIND_APPEND, 5,          16'h0f0f, 16'hf0f0, 8'd0,   1, ST_FULL},
    '{KIND_INSERT, 6,          16'hf0f0, 16'h0f0f, 8'd1,   1, ST_FULL},
    '{KIND_LIST,   0,          16'h0000, 16'h0000, 8'd0,   0, ST_OK},
    '{KIND_DELETE, 0,          16'h0000, 16'h0000, 8'd32,  1, ST_OK},
    '{KIND_DELETE, 0,          16'h0000, 16'h0000, 8'd32,  1, ST_BAD_POS}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void push_reply(status_t st, logic signed [31:0] id,
                                     logic [15:0] c1, logic [15:0] c2,
                                     logic [6:0] pos, logic last);
    list_reply_t r;
    r.status = st;
    r.id = id;
    r.first_code = c1;
    r.second_code = c2;
    r.pos = pos;
    r.last = last;
    pending_replies.push_back(r);
  endfunction

  // apply one command to the shadow list and queue the replies it causes
  function automatic void predict_command(cmd_row_t c);
    int idx;
    int eff;
    int i;
    bit found;
    status_t st;
    case (c.kind) inside
      KIND_APPEND, KIND_INSERT: begin
        if (shadow_count >= DEPTH) begin
          push_reply(ST_FULL, 0, 0, 0, 0, 1'b1);
        end else begin
          st = ST_OK;
          if (c.kind == KIND_APPEND) begin
            idx = shadow_count;
          end else if (c.pos == 8'd1) begin
            idx = 0;
          end else begin
            // position zero behaves as position two
            eff = (c.pos == 8'd0) ? 2 : int'(c.pos);
            if (shadow_count == 0 || eff - 1 > shadow_count) begin
              idx = shadow_count;
              st = ST_AT_END;
            end else begin
              idx = eff - 1;
            end
          end
          for (i = shadow_count; i > idx; i--) begin
            shadow_ids[i] = shadow_ids[i-1];
            shadow_first[i] = shadow_first[i-1];
            shadow_second[i] = shadow_second[i-1];
          end
          shadow_ids[idx] = c.id;
          shadow_first[idx] = c.first_code;
          shadow_second[idx] = c.second_code;
          shadow_count++;
          push_reply(st, 0, 0, 0, 0, 1'b1);
        end
      end
      KIND_UPDATE: begin
        found = 1'b0;
        for (i = 0; i < shadow_count && !found; i++) begin
          if (shadow_ids[i] == c.id) begin
            shadow_first[i] = c.first_code;
            shadow_second[i] = c.second_code;
            found = 1'b1;
          end
        end
        push_reply(found ? ST_OK : ST_NOT_FOUND, 0, 0, 0, 0, 1'b1);
      end
      KIND_DELETE: begin
        if (shadow_count == 0) begin
          push_reply(ST_EMPTY, 0, 0, 0, 0, 1'b1);
        end else if (c.pos == 8'd0 || int'(c.pos) > shadow_count) begin
          push_reply(ST_BAD_POS, 0, 0, 0, 0, 1'b1);
        end else begin
          for (i = int'(c.pos) - 1; i + 1 < shadow_count; i++) begin
            shadow_ids[i] = shadow_ids[i+1];
            shadow_first[i] = shadow_first[i+1];
            shadow_second[i] = shadow_second[i+1];
          end
          shadow_count--;
          push_reply(ST_OK, 0, 0, 0, 0, 1'b1);
        end
      end
      KIND_LIST: begin
        if (shadow_count == 0) begin
          push_reply(ST_EMPTY, 0, 0, 0, 0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            push_reply(ST_OK, shadow_ids[i], shadow_first[i], shadow_second[i],
                       7'(i + 1), i + 1 == shadow_count);
          end
        end
      end
      default: push_reply(ST_OK, 0, 0, 0, 0, 1'b1);
    endcase
  endfunction

  // offer one command on s_axis and return at the edge that accepts it
  task automatic send_command(cmd_row_t c);
    int queued;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.kind;
    s_axis_tdata <= {c.pos, c.second_code, c.first_code, c.id};
    queued = pending_replies.size();
    predict_command(c);
    if (c.typed) begin
      // hand-typed status replaces the predicted single reply
      while (pending_replies.size() > queued) void'(pending_replies.pop_back());
      push_reply(c.want, 0, 0, 0, 0, 1'b1);
    end
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic signed [31:0] roll_id(bit from_list);
    int sel;
    if (from_list && shadow_count > 0 && $urandom_range(0, 9) < 7)
      return shadow_ids[$urandom_range(0, shadow_count - 1)];
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 7);
    if (sel == 5) return $urandom_range(0, 1) ? ID_MIN : ID_MAX;
    return $urandom;
  endfunction

  // phase 0 churns, phase 1 grows toward full, phase 2 drains toward empty
  function automatic cmd_row_t roll_command(int phase);
    cmd_row_t c;
    int r;
    int w_app;
    int w_ins;
    int w_del;
    int w_upd;
    int w_lst;
    case (phase)
      1:       begin w_app = 36; w_ins = 30; w_del = 14; w_upd = 10; w_lst = 6; end
      2:       begin w_app = 10; w_ins = 10; w_del = 56; w_upd = 12; w_lst = 8; end
      default: begin w_app = 22; w_ins = 22; w_del = 30; w_upd = 14; w_lst = 8; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_app) c.kind = KIND_APPEND;
    else if (r < w_app + w_ins) c.kind = KIND_INSERT;
    else if (r < w_app + w_ins + w_del) c.kind = KIND_DELETE;
    else if (r < w_app + w_ins + w_del + w_upd) c.kind = KIND_UPDATE;
    else if (r < w_app + w_ins + w_del + w_upd + w_lst) c.kind = KIND_LIST;
    else c.kind = 3'($urandom_range(KIND_RSVD5, KIND_RSVD7));
    c.id = roll_id(c.kind == KIND_UPDATE);
    c.first_code = 16'($urandom_range(0, 65535));
    c.second_code = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) < 7) c.pos = 8'($urandom_range(0, shadow_count + 2));
    else c.pos = 8'($urandom_range(0, 255));
    c.typed = 1'b0;
    c.want = ST_OK;
    return c;
  endfunction

  // receiver: random back-pressure plus one long hold-off
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // check every reply transfer against the oldest expectation
  always @(posedge clk) begin
    list_reply_t exp_r;
    list_reply_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = status_t'(m_axis_tdata[2:0]);
      got.id = m_axis_tdata[34:3];
      got.first_code = m_axis_tdata[50:35];
      got.second_code = m_axis_tdata[66:51];
      got.pos = m_axis_tdata[73:67];
      got.last = m_axis_tlast;
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected reply: status %0d id %0d pos %0d last %0b",
                   got.status, got.id, got.pos, got.last);
      end else begin
        exp_r = pending_replies.pop_front();
        if (got.status !== exp_r.status || got.id !== exp_r.id ||
            got.first_code !== exp_r.first_code ||
            got.second_code !== exp_r.second_code ||
            got.pos !== exp_r.pos || got.last !== exp_r.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("reply mismatch at %0t", $realtime);
            $display("  expected: status %0d id %0d codes %h %h pos %0d last %0b",
                     exp_r.status, exp_r.id, exp_r.first_code, exp_r.second_code,
                     exp_r.pos, exp_r.last);
            $display("  actual:   status %0d id %0d codes %h %h pos %0d last %0b",
                     got.status, got.id, got.first_code, got.second_code,
                     got.pos, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_list_table verification failed");
      $finish;
    end
  end

  initial begin
    cmd_row_t c;
    int i;
    rst = 1'b1;
    calm = 1'b0;
    hold_request = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    shadow_count = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (opening_rows[k]) send_command(opening_rows[k]);

    // fill to capacity with random records
    while (shadow_count < DEPTH) begin
      c = roll_command(1);
      c.kind = KIND_APPEND;
      send_command(c);
    end
    foreach (full_rows[k]) send_command(full_rows[k]);

    for (i = 0; i < RANDOM_CMDS; i++) begin
      if (i == 30) hold_request = 1'b1;
      calm = (i >= 120 && i < 180);
      send_command(roll_command(i / 100));
    end
    calm = 1'b0;
    @(negedge clk) s_axis_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("positional_list_table verification clean");
    end else begin
      $display("positional_list_table verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
